// File: src/gle_pkg.sv
// Shared request/response types and codes for the gap-buffer line editor.
package gle_pkg;

  localparam logic [2:0] REQ_INSERT    = 3'd0;
  localparam logic [2:0] REQ_LEFT      = 3'd1;
  localparam logic [2:0] REQ_RIGHT     = 3'd2;
  localparam logic [2:0] REQ_BACKSPACE = 3'd3;
  localparam logic [2:0] REQ_READ      = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BEYOND  = 2'd3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_in;
    logic [9:0] position;
  } req_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic [1:0]  status;
    logic [10:0] text_length;
    logic [10:0] cursor;
  } rsp_t;

endpackage

// File: src/gle_text_ram.sv
// Single-port-write, registered-read byte memory holding the two text stacks.
module gle_text_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/gap_buffer_line_editor_core.sv
// Gap-buffer line editor core: a text line with a cursor kept as two stacks in one memory.
// Each request (insert, cursor left, cursor right, backspace, indexed read) yields exactly
// one response carrying the read character, a status code and the text length and cursor
// after the request. The request transaction issues the memory read at the gap edge or
// the read position, and the completion of the request uses the registered read data to
// write back and update the counts; the single registered memory read port is why the
// work is split so. A new request is taken once the previous one has been written into
// the response register, so a response waiting on a stalled consumer holds off at most
// the completion of the following request. The text memory needs no clearing after
// reset: only read data from entries that hold text is ever used.
module gap_buffer_line_editor_core
  import gle_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 10) ? CW : 10;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

  logic [CW-1:0] left_count, left_count_next;
  logic [CW-1:0] right_count, right_count_next;
  logic          pending;
  req_t          req_q;

  logic          accept;
  logic          finish;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [XW-1:0] rd_addr_x;
  logic [XW-1:0] left_x;
  logic [XW-1:0] right_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] pos_q_x;
  logic [CW-1:0] len;
  logic [CW-1:0] len_next;
  logic [CW-1:0] gap_top;
  logic [1:0]    status;
  logic [7:0]    char_rd;
  logic          write_req;

  assign req_stall = pending;
  assign accept    = req_valid && !pending;
  assign finish    = pending && (!rsp_valid || !rsp_stall);

  assign left_x  = XW'(left_count);
  assign right_x = XW'(right_count);
  assign pos_x   = XW'(req.position);
  assign pos_q_x = XW'(req_q.position);

  // Read address for the incoming request, from the counts as they stand.
  always_comb begin
    case (req.req_type)
      REQ_LEFT:  rd_addr_x = left_x - XW'(1);
      REQ_RIGHT: rd_addr_x = CAP_X - right_x;
      REQ_READ: begin
        if (pos_x < left_x) begin
          rd_addr_x = pos_x;
        end else begin
          rd_addr_x = CAP_X - right_x + (pos_x - left_x);
        end
      end
      default:   rd_addr_x = '0;
    endcase
  end

  assign ram_raddr = rd_addr_x[AW-1:0];

  assign len     = left_count + right_count;
  assign gap_top = CAP_C - right_count - CW'(1);

  // Complete the held request with the registered read data.
  always_comb begin
    left_count_next  = left_count;
    right_count_next = right_count;
    status           = ST_DONE;
    char_rd          = '0;
    write_req        = 1'b0;
    ram_waddr        = left_count[AW-1:0];
    ram_wdata        = req_q.char_in;
    case (req_q.req_type)
      REQ_INSERT: begin
        if (len >= CAP_C) begin
          status = ST_FULL;
        end else begin
          write_req       = 1'b1;
          left_count_next = left_count + CW'(1);
        end
      end
      REQ_LEFT: begin
        if (left_count == '0) begin
          status = ST_IGNORED;
        end else begin
          write_req        = 1'b1;
          ram_waddr        = gap_top[AW-1:0];
          ram_wdata        = ram_rdata;
          left_count_next  = left_count - CW'(1);
          right_count_next = right_count + CW'(1);
        end
      end
      REQ_RIGHT: begin
        if (right_count == '0) begin
          status = ST_IGNORED;
        end else begin
          write_req        = 1'b1;
          ram_wdata        = ram_rdata;
          left_count_next  = left_count + CW'(1);
          right_count_next = right_count - CW'(1);
        end
      end
      REQ_BACKSPACE: begin
        if (left_count == '0) begin
          status = ST_IGNORED;
        end else begin
          left_count_next = left_count - CW'(1);
        end
      end
      REQ_READ: begin
        if (pos_q_x >= XW'(len)) begin
          status = ST_BEYOND;
        end else begin
          char_rd = ram_rdata;
        end
      end
      default: status = ST_IGNORED;
    endcase
  end

  // Reads happen only on a request transaction and writes only on completion,
  // and the two never share a cycle, so no forwarding is needed.
  assign ram_we   = finish && write_req;
  assign len_next = left_count_next + right_count_next;

  gle_text_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= 1'b0;
      left_count  <= '0;
      right_count <= '0;
    end else begin
      if (accept) begin
        pending <= 1'b1;
      end else if (finish) begin
        pending     <= 1'b0;
        left_count  <= left_count_next;
        right_count <= right_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.char_out    <= char_rd;
      rsp.status      <= status;
      rsp.text_length <= 11'(len_next);
      rsp.cursor      <= 11'(left_count_next);
    end
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (XW'(left_count) + XW'(right_count)) <= CAP_X)
    else $error("text length exceeds capacity");

  a_counts_hold: assert property (@(posedge clk) disable iff (rst)
    !finish |=> $stable(left_count) && $stable(right_count))
    else $error("counts changed without a completed request");

  a_no_read_write: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && accept))
    else $error("memory read and write in the same cycle");

  a_rsp_after_finish: assert property (@(posedge clk) disable iff (rst)
    finish |=> rsp_valid && !pending)
    else $error("completed request did not load the response register");
`endif

endmodule
